@@ sv/lmd_pkg.sv @@
package lmd_pkg;

   // configuration port
   localparam int CFG_WIDTH       = 11;
   localparam int CSR_INDEX_WIDTH = 1;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_ROWS = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_COLS = 1'b1;

   // reset and minimum frame size
   localparam int FRAME_DIM_RESET = 4;
   localparam int FRAME_DIM_MIN   = 3;

   // result field widths
   localparam int COORD_WIDTH = 10;
   localparam int COUNT_WIDTH = 20;
   localparam logic [COUNT_WIDTH-1:0] COUNT_SAT = {COUNT_WIDTH{1'b1}};

endpackage

@@ sv/local_max_3x3_detector.sv @@
// Pipeline: an accepted request goes to the input register, then to the result register.
// Throughput: one request per clock unless the result channel stalls; the input
// register and the result register let a request enter while a result waits, and
// the line stores take one read and one write per cycle at different columns.
// Reset: synchronous, active high; clears the pipeline valids, the row/column
// position and the maxima count, and sets the frame size to 4 x 4.
module local_max_3x3_detector #(
   parameter int MAX_COLS     = 1024,
   parameter int MAX_ROWS     = 1024,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_write_en,
   input  logic [lmd_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [lmd_pkg::CFG_WIDTH-1:0]          csr_data,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_sample,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_found,
   output logic [lmd_pkg::COORD_WIDTH-1:0]        rsp_center_row,
   output logic [lmd_pkg::COORD_WIDTH-1:0]        rsp_center_col,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_center_value,
   output logic [lmd_pkg::COUNT_WIDTH-1:0]        rsp_max_count,
   output logic                                   rsp_frame_end
);

   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COLD_W = $clog2(MAX_COLS + 1);
   localparam int ROWD_W = $clog2(MAX_ROWS + 1);

   // frame size and position
   logic [ROWD_W-1:0] frame_rows_ff, frame_rows_in;
   logic [COLD_W-1:0] frame_cols_ff, frame_cols_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              last_pos;

   // input register stage
   logic                           s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] s1_sample_ff;
   logic [ROW_W-1:0]               s1_row_ff;
   logic [COL_W-1:0]               s1_col_ff;
   logic                           s1_last_ff;

   // line stores and their registered read data
   logic signed [SAMPLE_WIDTH-1:0] store_a [MAX_COLS];
   logic signed [SAMPLE_WIDTH-1:0] store_b [MAX_COLS];
   logic signed [SAMPLE_WIDTH-1:0] a_rd_ff, b_rd_ff;

   // window
   logic signed [SAMPLE_WIDTH-1:0] win_ff [3][3];
   logic signed [SAMPLE_WIDTH-1:0] win_in [3][3];

   // evaluation
   logic                           req_fire, rsp_fire, s1_move;
   logic                           first_pos, interior, found;
   logic [lmd_pkg::COUNT_WIDTH-1:0] count_ff, count_in, count_base;
   logic [31:0]                    cfg_wide, rows_clamp, cols_clamp;

   // handshake
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign s1_move   = s1_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign req_fire  = req_valid && !req_stall;

   // clamp written frame dimensions
   always_comb begin
      cfg_wide   = 32'(csr_data);
      rows_clamp = cfg_wide;
      cols_clamp = cfg_wide;
      if (cfg_wide < 32'(lmd_pkg::FRAME_DIM_MIN)) begin
         rows_clamp = 32'(lmd_pkg::FRAME_DIM_MIN);
         cols_clamp = 32'(lmd_pkg::FRAME_DIM_MIN);
      end
      if (cfg_wide > 32'(MAX_ROWS)) begin
         rows_clamp = 32'(MAX_ROWS);
      end
      if (cfg_wide > 32'(MAX_COLS)) begin
         cols_clamp = 32'(MAX_COLS);
      end
   end

   // advance raster position; any register write restarts the frame
   always_comb begin
      frame_rows_in = frame_rows_ff;
      frame_cols_in = frame_cols_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      last_pos      = (32'(row_ff) + 32'd1 >= 32'(frame_rows_ff)) &&
                      (32'(col_ff) + 32'd1 >= 32'(frame_cols_ff));
      if (csr_write_en) begin
         unique case (csr_index)
            lmd_pkg::CSR_FRAME_ROWS: frame_rows_in = ROWD_W'(rows_clamp);
            lmd_pkg::CSR_FRAME_COLS: frame_cols_in = COLD_W'(cols_clamp);
            default: ;
         endcase
         row_in = '0;
         col_in = '0;
      end else if (req_fire) begin
         if (32'(col_ff) + 32'd1 >= 32'(frame_cols_ff)) begin
            col_in = '0;
            if (32'(row_ff) + 32'd1 >= 32'(frame_rows_ff)) begin
               row_in = '0;
            end else begin
               row_in = ROW_W'(32'(row_ff) + 32'd1);
            end
         end else begin
            col_in = COL_W'(32'(col_ff) + 32'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_rows_ff <= ROWD_W'(lmd_pkg::FRAME_DIM_RESET);
         frame_cols_ff <= COLD_W'(lmd_pkg::FRAME_DIM_RESET);
         row_ff        <= '0;
         col_ff        <= '0;
      end else begin
         frame_rows_ff <= frame_rows_in;
         frame_cols_ff <= frame_cols_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
      end
   end

   // input register: hold the request until it moves to the result
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_sample_ff <= req_sample;
         s1_row_ff    <= row_ff;
         s1_col_ff    <= col_ff;
         s1_last_ff   <= last_pos;
      end
   end

   // line store A: read on accept, write the new sample on move
   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_rd_ff <= store_a[col_ff];
      end
      if (s1_move) begin
         store_a[s1_col_ff] <= s1_sample_ff;
      end
   end

   // line store B: takes the row that leaves store A
   always_ff @(posedge clock) begin
      if (req_fire) begin
         b_rd_ff <= store_b[col_ff];
      end
      if (s1_move) begin
         store_b[s1_col_ff] <= a_rd_ff;
      end
   end

   // shift the window one column and load the new column
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i][0] = win_ff[i][1];
         win_in[i][1] = win_ff[i][2];
      end
      win_in[0][2] = b_rd_ff;
      win_in[1][2] = a_rd_ff;
      win_in[2][2] = s1_sample_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         win_ff <= win_in;
      end
   end

   // compare the center against its eight neighbors and update the count
   always_comb begin
      first_pos = (s1_row_ff == '0) && (s1_col_ff == '0);
      interior  = (32'(s1_row_ff) >= 32'd2) && (32'(s1_col_ff) >= 32'd2);
      found     = interior;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (!(i == 1 && j == 1) && !(win_in[i][j] < win_in[1][1])) begin
               found = 1'b0;
            end
         end
      end
      count_base = first_pos ? '0 : count_ff;
      count_in   = count_base;
      if (found && (count_base != lmd_pkg::COUNT_SAT)) begin
         count_in = count_base + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (s1_move) begin
         count_ff <= count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (s1_move) begin
         rsp_valid <= 1'b1;
      end else if (rsp_fire) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_found     <= found;
         rsp_max_count <= count_in;
         rsp_frame_end <= s1_last_ff;
         if (interior) begin
            rsp_center_row   <= lmd_pkg::COORD_WIDTH'(32'(s1_row_ff) - 32'd1);
            rsp_center_col   <= lmd_pkg::COORD_WIDTH'(32'(s1_col_ff) - 32'd1);
            rsp_center_value <= win_in[1][1];
         end else begin
            rsp_center_row   <= '0;
            rsp_center_col   <= '0;
            rsp_center_value <= '0;
         end
      end
   end

   // checks
   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid && rsp_stall) |-> req_stall)
      else $error("input register overrun");

   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < 32'(frame_cols_ff))
      else $error("column position outside frame");

   a_found_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_max_count != '0))
      else $error("maximum reported with zero count");

   a_found_interior: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_center_row != '0 && rsp_center_col != '0))
      else $error("maximum reported on frame border");

endmodule
